// File: hw/rtl/ccpc_pkg.sv
// Shared constants and types for the conic curve pixel classifier.
`timescale 1ns / 1ps
`default_nettype none
package ccpc_pkg;

	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 4;

	localparam int MAG_W  = (COORD_BITS > 10) ? COORD_BITS : 10;
	localparam int SQ_W   = 2 * MAG_W + 1 + 2 * FRAC_BITS;
	localparam int ROOT_W = (SQ_W + 1) / 2;
	localparam int V_W    = 2 * ROOT_W;
	localparam int CMP_W  = ROOT_W + 16;
	localparam int DD_W   = MAG_W + FRAC_BITS;
	localparam int NLANE  = 5;
	localparam int NSTG   = ROOT_W + 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X  = 3'd0,
		REG_CENTER_Y  = 3'd1,
		REG_RADIUS    = 3'd2,
		REG_ELL_SUM   = 3'd3,
		REG_HYP_DIFF  = 3'd4,
		REG_DIRX      = 3'd5,
		REG_TOLERANCE = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CLS_NONE      = 3'd0,
		CLS_CIRCLE    = 3'd1,
		CLS_ELLIPSE   = 3'd2,
		CLS_HYPERBOLA = 3'd3,
		CLS_PARABOLA  = 3'd4
	} curve_class_t;

	localparam logic [9:0]  RST_CENTER_X  = 10'd320;
	localparam logic [9:0]  RST_CENTER_Y  = 10'd240;
	localparam logic [10:0] RST_RADIUS    = 11'd200;
	localparam logic [11:0] RST_ELL_SUM   = 12'd250;
	localparam logic [10:0] RST_HYP_DIFF  = 11'd100;
	localparam logic [9:0]  RST_DIRX      = 10'd400;
	localparam logic [7:0]  RST_TOLERANCE = 8'd19;

	// ellipse A, ellipse B, hyperbola A, hyperbola B
	localparam logic [MAG_W-1:0] FOCUS_X [4] = '{
		MAG_W'(240), MAG_W'(400), MAG_W'(240), MAG_W'(400)};
	localparam logic [MAG_W-1:0] FOCUS_Y [4] = '{
		MAG_W'(200), MAG_W'(280), MAG_W'(240), MAG_W'(240)};

	typedef struct packed {
		logic [ROOT_W+1:0] r;
		logic [ROOT_W-1:0] q;
		logic [V_W-1:0]    v;
	} sqrt_lane_t;

endpackage
`default_nettype wire

// File: hw/rtl/conic_curve_pixel_classifier.sv
// Top level of the conic curve pixel classifier pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Classifies one pixel per clock against a circle, an ellipse, a hyperbola and a
// parabola, first match wins. The pipeline is ccpc_pkg::NSTG stages deep
// (ROOT_W + 4, 19 with the default widths): offsets, squares, one stage per
// square-root result bit, differences, then the class register. One pixel is
// accepted every cycle while in_stall is low; each stage holds independently
// under out_stall, so bubbles are squeezed out. Configuration writes are taken
// at any time with cfg_ready high and should be made while the pipeline is empty.
module conic_curve_pixel_classifier (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [ccpc_pkg::COORD_BITS-1:0]    pixel_x,
	input  wire logic [ccpc_pkg::COORD_BITS-1:0]    pixel_y,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [2:0]                              curve_class,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ccpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ccpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int MW = ccpc_pkg::MAG_W;
	localparam int RW = ccpc_pkg::ROOT_W;
	localparam int CW = ccpc_pkg::CMP_W;
	localparam int FB = ccpc_pkg::FRAC_BITS;
	localparam int NS = ccpc_pkg::NSTG;
	localparam int NL = ccpc_pkg::NLANE;

	logic [9:0]  cx_q, cy_q, dirx_q;
	logic [10:0] rad_q, hdiff_q;
	logic [11:0] esum_q;
	logic [7:0]  tol_q;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	logic [MW-1:0]           adx_s1 [NL];
	logic [MW-1:0]           ady_s1 [NL];
	logic [ccpc_pkg::DD_W-1:0] dd_sq [NS-2];
	ccpc_pkg::sqrt_lane_t    sqrt_sq [RW+1][NL];
	logic signed [CW-1:0]    d_circ_sd, d_ell_sd, d_hp_sd, d_hm_sd, d_par_sd;
	logic [2:0]              cls_q;

	logic [MW-1:0] lane_x [NL];
	logic [MW-1:0] lane_y [NL];
	logic [MW-1:0] px_ext, py_ext;
	logic signed [MW:0] dx_c [NL];
	logic signed [MW:0] dy_c [NL];
	logic signed [MW:0] dd_c;
	ccpc_pkg::sqrt_lane_t step_c [RW][NL];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q    <= ccpc_pkg::RST_CENTER_X;
			cy_q    <= ccpc_pkg::RST_CENTER_Y;
			rad_q   <= ccpc_pkg::RST_RADIUS;
			esum_q  <= ccpc_pkg::RST_ELL_SUM;
			hdiff_q <= ccpc_pkg::RST_HYP_DIFF;
			dirx_q  <= ccpc_pkg::RST_DIRX;
			tol_q   <= ccpc_pkg::RST_TOLERANCE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ccpc_pkg::REG_CENTER_X:  cx_q    <= cfg_data[9:0];
				ccpc_pkg::REG_CENTER_Y:  cy_q    <= cfg_data[9:0];
				ccpc_pkg::REG_RADIUS:    rad_q   <= cfg_data[10:0];
				ccpc_pkg::REG_ELL_SUM:   esum_q  <= cfg_data[11:0];
				ccpc_pkg::REG_HYP_DIFF:  hdiff_q <= cfg_data[10:0];
				ccpc_pkg::REG_DIRX:      dirx_q  <= cfg_data[9:0];
				ccpc_pkg::REG_TOLERANCE: tol_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// stage enables: advance when empty or when the next stage moves
	always_comb begin
		en[NS-1] = !vld_q[NS-1] || !out_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: absolute offsets
	always_comb begin
		px_ext = MW'(pixel_x);
		py_ext = MW'(pixel_y);
		lane_x[0] = MW'(cx_q);
		lane_y[0] = MW'(cy_q);
		for (int l = 1; l < NL; l++) begin
			lane_x[l] = ccpc_pkg::FOCUS_X[l-1];
			lane_y[l] = ccpc_pkg::FOCUS_Y[l-1];
		end
		for (int l = 0; l < NL; l++) begin
			dx_c[l] = $signed({1'b0, px_ext}) - $signed({1'b0, lane_x[l]});
			dy_c[l] = $signed({1'b0, py_ext}) - $signed({1'b0, lane_y[l]});
		end
		dd_c = $signed({1'b0, px_ext}) - $signed({1'b0, MW'(dirx_q)});
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int l = 0; l < NL; l++) begin
				adx_s1[l] <= dx_c[l][MW] ? MW'(-dx_c[l]) : dx_c[l][MW-1:0];
				ady_s1[l] <= dy_c[l][MW] ? MW'(-dy_c[l]) : dy_c[l][MW-1:0];
			end
		end
	end

	// square root, one result bit per stage
	always_comb begin
		for (int j = 0; j < RW; j++) begin
			for (int l = 0; l < NL; l++) begin
				step_c[j][l].r = {sqrt_sq[j][l].r[RW-1:0],
					sqrt_sq[j][l].v[ccpc_pkg::V_W-1 -: 2]};
				step_c[j][l].v = {sqrt_sq[j][l].v[ccpc_pkg::V_W-3:0], 2'b00};
				if (step_c[j][l].r >= {sqrt_sq[j][l].q, 2'b01}) begin
					step_c[j][l].r = step_c[j][l].r - {sqrt_sq[j][l].q, 2'b01};
					step_c[j][l].q = {sqrt_sq[j][l].q[RW-2:0], 1'b1};
				end else begin
					step_c[j][l].q = {sqrt_sq[j][l].q[RW-2:0], 1'b0};
				end
			end
		end
	end

	// directrix distance, squared distance scaled for the fraction bits, root stages
	always_ff @(posedge clk) begin
		if (en[0]) begin
			dd_sq[0] <= {(dd_c[MW] ? MW'(-dd_c) : dd_c[MW-1:0]), FB'(0)};
		end
		if (en[1]) begin
			for (int l = 0; l < NL; l++) begin
				sqrt_sq[0][l].r <= '0;
				sqrt_sq[0][l].q <= '0;
				sqrt_sq[0][l].v <= ccpc_pkg::V_W'(
					{(2*MW+1)'(adx_s1[l] * adx_s1[l]) + (2*MW+1)'(ady_s1[l] * ady_s1[l]),
					 (2*FB)'(0)});
			end
			dd_sq[1] <= dd_sq[0];
		end
		for (int j = 0; j < RW; j++) begin
			if (en[j+2]) begin
				sqrt_sq[j+1] <= step_c[j];
				dd_sq[j+2]   <= dd_sq[j+1];
			end
		end
	end

	// differences against the targets
	always_ff @(posedge clk) begin
		if (en[NS-2]) begin
			d_circ_sd <= CW'(sqrt_sq[RW][0].q) - CW'({rad_q, FB'(0)});
			d_ell_sd  <= CW'(sqrt_sq[RW][1].q) + CW'(sqrt_sq[RW][2].q)
				- CW'({esum_q, FB'(0)});
			d_hp_sd   <= CW'(sqrt_sq[RW][3].q) - CW'(sqrt_sq[RW][4].q)
				- CW'({hdiff_q, FB'(0)});
			d_hm_sd   <= CW'(sqrt_sq[RW][3].q) - CW'(sqrt_sq[RW][4].q)
				+ CW'({hdiff_q, FB'(0)});
			d_par_sd  <= CW'(sqrt_sq[RW][0].q) - CW'(dd_sq[NS-3]);
		end
	end

	function automatic logic near_tol(input logic signed [CW-1:0] d, input logic [7:0] t);
		logic [CW-1:0] m;
		m = d[CW-1] ? CW'(-d) : CW'(d);
		return m < CW'(t);
	endfunction

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			if (near_tol(d_circ_sd, tol_q)) begin
				cls_q <= ccpc_pkg::CLS_CIRCLE;
			end else if (near_tol(d_ell_sd, tol_q)) begin
				cls_q <= ccpc_pkg::CLS_ELLIPSE;
			end else if (near_tol(d_hp_sd, tol_q) || near_tol(d_hm_sd, tol_q)) begin
				cls_q <= ccpc_pkg::CLS_HYPERBOLA;
			end else if (near_tol(d_par_sd, tol_q)) begin
				cls_q <= ccpc_pkg::CLS_PARABOLA;
			end else begin
				cls_q <= ccpc_pkg::CLS_NONE;
			end
		end
	end

	assign curve_class = cls_q;

endmodule
`default_nettype wire

// File: hw/rtl/ccpc_checker.sv
// Port-level checker for the conic curve pixel classifier, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module ccpc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] curve_class,
	input wire logic       cfg_ready
);
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(curve_class))
		else $error("stalled request changed");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> curve_class <= ccpc_pkg::CLS_PARABOLA)
		else $error("class code out of range");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");
endmodule

bind conic_curve_pixel_classifier ccpc_checker u_ccpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.curve_class (curve_class),
	.cfg_ready   (cfg_ready)
);
`default_nettype wire
